// ===== hdl/edid_hdr_pkg.sv =====
// ---------------------------------------------------------------------------
// EDID HDR parser package
// Shared constants and types for the EDID HDR capability parser.
// ---------------------------------------------------------------------------
package edid_hdr_pkg;

    // Block geometry
    localparam logic [6:0] POS_EXT_COUNT = 7'd126;
    localparam logic [6:0] POS_LAST      = 7'd127;
    localparam logic [6:0] POS_TAG       = 7'd0;
    localparam logic [6:0] POS_DTD_OFS   = 7'd2;
    localparam logic [6:0] POS_FIRST_HDR = 7'd4;

    // Extension tag and data-block area limits
    localparam logic [7:0] CTA_TAG       = 8'h02;
    localparam logic [7:0] DATA_END_DFLT = 8'd127;
    localparam logic [7:0] DATA_END_MIN  = 8'd4;
    localparam logic [7:0] DATA_END_MAX  = 8'd128;
    localparam logic [7:0] FIRST_HDR_AT  = 8'd4;

    // Data-block header fields
    localparam logic [2:0] HDR_CODE_EXT  = 3'd7;

    // Extended tags
    localparam logic [7:0] EXT_TAG_HDR   = 8'h06;
    localparam logic [7:0] EXT_TAG_COLOR = 8'h05;
    localparam logic [4:0] HDR_MIN_LEN   = 5'd3;
    localparam logic [4:0] COLOR_MIN_LEN = 5'd2;

    // Payload bit positions
    localparam int EOTF_PQ_BIT  = 2;
    localparam int EOTF_HLG_BIT = 3;
    localparam int COLOR_YCC_BIT = 6;

    // Block counter saturation
    localparam logic [8:0] BLOCK_NUM_MAX = 9'd511;

    // Capability flags, bit 0 PQ upward
    typedef struct packed {
        logic ycc;
        logic hlg;
        logic pq;
    } hdr_flags_t;

    // Result from the parser core to the output buffer
    typedef struct packed {
        logic       valid;
        hdr_flags_t flags;
    } hdr_result_t;

endpackage

// ===== hdl/edid_hdr_core.sv =====
// ---------------------------------------------------------------------------
// EDID HDR parser core
// Walks the blob one word per valid cycle and updates position, block and
// capability state; emits the committed flags on the last word.
// ---------------------------------------------------------------------------
module edid_hdr_core
    import edid_hdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_valid,
    input  logic [7:0]  edid_byte,
    input  logic        last_byte,
    output hdr_result_t result
);

    logic [6:0] byte_in_block_reg, byte_in_block_next;
    logic [8:0] block_number_reg, block_number_next;
    logic [7:0] extension_count_reg, extension_count_next;
    logic       block_usable_reg, block_usable_next;
    logic [7:0] data_end_reg, data_end_next;
    logic [7:0] next_header_at_reg, next_header_at_next;
    logic [4:0] payload_length_reg, payload_length_next;
    logic [4:0] payload_index_reg, payload_index_next;
    logic       extended_block_reg, extended_block_next;
    logic [7:0] extended_tag_reg, extended_tag_next;
    logic       walk_stopped_reg, walk_stopped_next;
    hdr_flags_t pending_flags_reg, pending_flags_next;
    hdr_flags_t committed_flags_reg, committed_flags_next;

    logic       parsed;
    logic [7:0] pos_ext;
    logic [7:0] de_value;
    logic [7:0] hdr_end;
    logic [4:0] hdr_len;

    assign pos_ext = {1'b0, byte_in_block_reg};
    assign parsed  = (block_number_reg >= 9'd1) &&
                     (block_number_reg <= {1'b0, extension_count_reg});
    assign de_value = (edid_byte == 8'd0) ? DATA_END_DFLT : edid_byte;
    assign hdr_len  = edid_byte[4:0];
    assign hdr_end  = pos_ext + 8'd1 + {3'b000, hdr_len};

    // Compute the state after one word
    always_comb begin
        byte_in_block_next   = byte_in_block_reg;
        block_number_next    = block_number_reg;
        extension_count_next = extension_count_reg;
        block_usable_next    = block_usable_reg;
        data_end_next        = data_end_reg;
        next_header_at_next  = next_header_at_reg;
        payload_length_next  = payload_length_reg;
        payload_index_next   = payload_index_reg;
        extended_block_next  = extended_block_reg;
        extended_tag_next    = extended_tag_reg;
        walk_stopped_next    = walk_stopped_reg;
        pending_flags_next   = pending_flags_reg;
        committed_flags_next = committed_flags_reg;
        result               = '0;

        if (byte_valid) begin
            // Capture the extension count from the base block
            if (block_number_reg == 9'd0 && byte_in_block_reg == POS_EXT_COUNT) begin
                extension_count_next = edid_byte;
            end

            if (parsed) begin
                if (byte_in_block_reg == POS_TAG) begin
                    block_usable_next = (edid_byte == CTA_TAG);
                end else if (byte_in_block_reg == POS_DTD_OFS) begin
                    data_end_next = de_value;
                    if (de_value < DATA_END_MIN || de_value > DATA_END_MAX) begin
                        block_usable_next = 1'b0;
                    end
                end else if (byte_in_block_reg >= POS_FIRST_HDR && block_usable_reg &&
                             !walk_stopped_reg && pos_ext < data_end_reg) begin
                    // Walk data-block headers and payloads
                    if (pos_ext == next_header_at_reg) begin
                        if (hdr_end > data_end_reg) begin
                            walk_stopped_next = 1'b1;
                        end else begin
                            payload_length_next = hdr_len;
                            payload_index_next  = 5'd0;
                            extended_block_next = (edid_byte[7:5] == HDR_CODE_EXT);
                            next_header_at_next = hdr_end;
                        end
                    end else begin
                        if (extended_block_reg) begin
                            if (payload_index_reg == 5'd0) begin
                                extended_tag_next = edid_byte;
                            end else if (payload_index_reg == 5'd1) begin
                                if (extended_tag_reg == EXT_TAG_HDR &&
                                    payload_length_reg >= HDR_MIN_LEN) begin
                                    pending_flags_next.pq  = pending_flags_reg.pq |
                                                             edid_byte[EOTF_PQ_BIT];
                                    pending_flags_next.hlg = pending_flags_reg.hlg |
                                                             edid_byte[EOTF_HLG_BIT];
                                end else if (extended_tag_reg == EXT_TAG_COLOR &&
                                             payload_length_reg >= COLOR_MIN_LEN) begin
                                    pending_flags_next.ycc = pending_flags_reg.ycc |
                                                             edid_byte[COLOR_YCC_BIT];
                                end
                            end
                        end
                        payload_index_next = payload_index_reg + 5'd1;
                    end
                end

                // Commit pending flags at the end of a full block
                if (byte_in_block_reg == POS_LAST) begin
                    committed_flags_next = committed_flags_reg | pending_flags_next;
                end
            end

            // Clear per-block state and advance the block counter
            if (byte_in_block_reg == POS_LAST) begin
                block_usable_next   = 1'b0;
                data_end_next       = 8'd0;
                next_header_at_next = FIRST_HDR_AT;
                payload_length_next = 5'd0;
                payload_index_next  = 5'd0;
                extended_block_next = 1'b0;
                extended_tag_next   = 8'd0;
                walk_stopped_next   = 1'b0;
                pending_flags_next  = '0;
                if (block_number_reg < BLOCK_NUM_MAX) begin
                    block_number_next = block_number_reg + 9'd1;
                end
            end
            byte_in_block_next = byte_in_block_reg + 7'd1;

            // Emit the flags and start a fresh blob
            if (last_byte) begin
                result.valid         = 1'b1;
                result.flags         = committed_flags_next;
                byte_in_block_next   = 7'd0;
                block_number_next    = 9'd0;
                extension_count_next = 8'd0;
                committed_flags_next = '0;
                block_usable_next    = 1'b0;
                data_end_next        = 8'd0;
                next_header_at_next  = FIRST_HDR_AT;
                payload_length_next  = 5'd0;
                payload_index_next   = 5'd0;
                extended_block_next  = 1'b0;
                extended_tag_next    = 8'd0;
                walk_stopped_next    = 1'b0;
                pending_flags_next   = '0;
            end
        end
    end

    // Hold the parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_block_reg   <= 7'd0;
            block_number_reg    <= 9'd0;
            extension_count_reg <= 8'd0;
            block_usable_reg    <= 1'b0;
            data_end_reg        <= 8'd0;
            next_header_at_reg  <= FIRST_HDR_AT;
            payload_length_reg  <= 5'd0;
            payload_index_reg   <= 5'd0;
            extended_block_reg  <= 1'b0;
            extended_tag_reg    <= 8'd0;
            walk_stopped_reg    <= 1'b0;
            pending_flags_reg   <= '0;
            committed_flags_reg <= '0;
        end else begin
            byte_in_block_reg   <= byte_in_block_next;
            block_number_reg    <= block_number_next;
            extension_count_reg <= extension_count_next;
            block_usable_reg    <= block_usable_next;
            data_end_reg        <= data_end_next;
            next_header_at_reg  <= next_header_at_next;
            payload_length_reg  <= payload_length_next;
            payload_index_reg   <= payload_index_next;
            extended_block_reg  <= extended_block_next;
            extended_tag_reg    <= extended_tag_next;
            walk_stopped_reg    <= walk_stopped_next;
            pending_flags_reg   <= pending_flags_next;
            committed_flags_reg <= committed_flags_next;
        end
    end

endmodule

// ===== hdl/edid_hdr_capability_parser_top.sv =====
// ---------------------------------------------------------------------------
// EDID HDR capability parser, top level
// Feed an EDID blob one word per cycle on the s_ channel: tdata carries
// the raw byte, tlast marks the final byte of the blob. The parser reads
// the extension count from the base block, walks the CTA-861 data blocks
// of each announced extension, and on the last byte sends one result word
// on the m_ channel with the PQ, HLG and BT.2020 YCC capability flags.
// Throughput: one input word per cycle while s_tready is high. The result
// reaches m_ through the output register once the last byte is accepted.
// The per-byte state update is one level of counters and compares ahead
// of the state registers, so every accepted word finishes in its own cycle.
// If the receiver stalls, the pending result is held in the output
// register and a second one in a skid register; s_tready drops only while
// the skid register is full.
// Reset (aresetn low, synchronous) clears the parse state and empties the
// output and skid registers; the next word starts a fresh blob.
// ---------------------------------------------------------------------------
module edid_hdr_capability_parser_top
    import edid_hdr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] edid_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] sink_pq, [1] sink_hlg, [2] sink_bt2020_ycc
);

    hdr_result_t result;
    logic        in_take;
    logic        out_take;
    logic        out_valid_reg;
    hdr_flags_t  out_flags_reg;
    logic        skid_valid_reg;
    hdr_flags_t  skid_flags_reg;

    assign s_tready = !skid_valid_reg;
    assign in_take  = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    edid_hdr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_take),
        .edid_byte  (s_tdata),
        .last_byte  (s_tlast),
        .result     (result)
    );

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_take) begin
            out_valid_reg <= result.valid;
        end else if (result.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move result payloads along with the valid bits
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_flags_reg <= skid_flags_reg;
            end
        end else if (!out_valid_reg || out_take) begin
            out_flags_reg <= result.flags;
        end else begin
            skid_flags_reg <= result.flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_flags_reg.ycc, out_flags_reg.hlg, out_flags_reg.pq};

endmodule

// ===== bench/tb_edid_hdr_capability_parser_top.sv =====
// ---------------------------------------------------------------------------
// Testbench for the EDID HDR capability parser top level
// Streams EDID blobs into the s_ channel one word per byte and checks each
// result word on the m_ channel against a cycle-free model of the parser.
// Directed blobs cover tag and data-end limits, short extended blocks,
// overrunning headers, truncation and blocks beyond the announced count.
// Random blobs follow, mostly well formed, with random idling on both sides,
// a long receiver stall and a sender pause until all results are in.
// ---------------------------------------------------------------------------
module tb_edid_hdr_capability_parser_top
    import edid_hdr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        GAP_NONE,
        GAP_FULL,
        GAP_SPARSE
    } gap_style_t;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
        int         gap;
        bit         wait_drain;
    } edid_word_t;

    localparam int HOLD_CYCLES  = 300;
    localparam int BURST_BLOBS  = 40;
    localparam int ITEM_TARGET  = 1750;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 100;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    // Words waiting to be sent and flags waiting to come back
    edid_word_t edid_word_q[$];
    hdr_flags_t hdr_flags_due_q[$];

    // Blob under construction and one extension block buffer
    logic [7:0] blob_q[$];
    logic [7:0] blk_buf[128];
    int         blk_fill;
    gap_style_t gap_style = GAP_SPARSE;

    int mismatch_cnt  = 0;
    int bytes_sent    = 0;
    int bytes_queued  = 0;
    int blobs_queued  = 0;
    int results_seen  = 0;
    int pq_seen       = 0;
    int hlg_seen      = 0;
    int ycc_seen      = 0;
    int hold_at       = 32'h7fff_ffff;
    int gap_left      = 0;
    int rx_wait       = 0;
    bit rx_calm       = 1'b0;
    logic long_hold   = 1'b0;

    // Parser model state
    logic [6:0] trk_pos;
    logic [8:0] trk_block;
    logic [7:0] trk_ext_cnt;
    logic       trk_usable;
    logic [7:0] trk_end;
    logic [7:0] trk_next_hdr;
    logic [4:0] trk_len;
    logic [4:0] trk_idx;
    logic       trk_ext;
    logic [7:0] trk_tag;
    logic       trk_stop;
    hdr_flags_t trk_pending;
    hdr_flags_t trk_committed;

    edid_hdr_capability_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("MISMATCH at %0t ns: %s", $realtime, what);
        end
        mismatch_cnt++;
    endtask

    // Drop the per-block walk state
    task automatic clear_ext_block();
        trk_usable   = 1'b0;
        trk_end      = 8'd0;
        trk_next_hdr = FIRST_HDR_AT;
        trk_len      = 5'd0;
        trk_idx      = 5'd0;
        trk_ext      = 1'b0;
        trk_tag      = 8'd0;
        trk_stop     = 1'b0;
        trk_pending  = '0;
    endtask

    // Return to the start of a fresh blob
    task automatic clear_blob();
        trk_pos       = 7'd0;
        trk_block     = 9'd0;
        trk_ext_cnt   = 8'd0;
        trk_committed = '0;
        clear_ext_block();
    endtask

    // Advance the model by one accepted byte; queue the flags on the last one
    task automatic track_edid_byte(input logic [7:0] edid_b, input logic is_last);
        logic [6:0] pos;
        logic       parsed;
        int         hdr_end;
        pos    = trk_pos;
        parsed = (trk_block >= 9'd1) && (trk_block <= {1'b0, trk_ext_cnt});
        if (trk_block == 9'd0 && pos == POS_EXT_COUNT) begin
            trk_ext_cnt = edid_b;
        end
        if (parsed) begin
            if (pos == POS_TAG) begin
                trk_usable = (edid_b == CTA_TAG);
            end else if (pos == POS_DTD_OFS) begin
                trk_end = (edid_b == 8'd0) ? DATA_END_DFLT : edid_b;
                if (trk_end < DATA_END_MIN || trk_end > DATA_END_MAX) begin
                    trk_usable = 1'b0;
                end
            end else if (pos >= POS_FIRST_HDR && trk_usable && !trk_stop
                         && {1'b0, pos} < trk_end) begin
                if ({1'b0, pos} == trk_next_hdr) begin
                    // Header byte: stop the walk if the payload runs past the end
                    hdr_end = int'(pos) + 1 + int'(edid_b[4:0]);
                    if (hdr_end > int'(trk_end)) begin
                        trk_stop = 1'b1;
                    end else begin
                        trk_len      = edid_b[4:0];
                        trk_idx      = 5'd0;
                        trk_ext      = (edid_b[7:5] == HDR_CODE_EXT);
                        trk_next_hdr = 8'(hdr_end);
                    end
                end else begin
                    if (trk_ext) begin
                        if (trk_idx == 5'd0) begin
                            trk_tag = edid_b;
                        end else if (trk_idx == 5'd1) begin
                            if (trk_tag == EXT_TAG_HDR && trk_len >= HDR_MIN_LEN) begin
                                if (edid_b[EOTF_PQ_BIT])  trk_pending.pq  = 1'b1;
                                if (edid_b[EOTF_HLG_BIT]) trk_pending.hlg = 1'b1;
                            end else if (trk_tag == EXT_TAG_COLOR
                                         && trk_len >= COLOR_MIN_LEN) begin
                                if (edid_b[COLOR_YCC_BIT]) trk_pending.ycc = 1'b1;
                            end
                        end
                    end
                    trk_idx = trk_idx + 5'd1;
                end
            end
            if (pos == POS_LAST) begin
                trk_committed = trk_committed | trk_pending;
            end
        end
        if (pos == POS_LAST) begin
            clear_ext_block();
            if (trk_block < BLOCK_NUM_MAX) trk_block = trk_block + 9'd1;
        end
        trk_pos = pos + 7'd1;
        if (is_last) begin
            hdr_flags_due_q = {hdr_flags_due_q, trk_committed};
            clear_blob();
        end
    endtask

    // Base block of random bytes with the given extension count
    task automatic add_base_block(input logic [7:0] ext_cnt);
        for (int i = 0; i < 128; i++) begin
            blob_q = {blob_q, (i == int'(POS_EXT_COUNT)) ? ext_cnt : 8'($urandom)};
        end
    endtask

    task automatic start_ext_block(input logic [7:0] tag, input logic [7:0] dtd_ofs);
        for (int i = 0; i < 128; i++) blk_buf[i] = 8'($urandom);
        blk_buf[POS_TAG]     = tag;
        blk_buf[POS_DTD_OFS] = dtd_ofs;
        blk_fill             = int'(FIRST_HDR_AT);
    endtask

    // Write one data-block header with its extended tag and payload byte 1
    task automatic put_data_block(input logic [2:0] code, input logic [4:0] len,
                                  input logic [7:0] etag, input logic [7:0] b1);
        if (blk_fill < 128) blk_buf[blk_fill] = {code, len};
        if (code == HDR_CODE_EXT) begin
            if (blk_fill + 1 < 128 && len > 5'd0) blk_buf[blk_fill + 1] = etag;
            if (blk_fill + 2 < 128 && len > 5'd1) blk_buf[blk_fill + 2] = b1;
        end
        blk_fill += 1 + int'(len);
    endtask

    task automatic push_ext_block();
        for (int i = 0; i < 128; i++) blob_q = {blob_q, blk_buf[i]};
    endtask

    // Chain random data blocks up to the data end; sparse blocks carry few hits
    task automatic fill_random_blocks(input int area_end, input bit sparse);
        int kind;
        while (blk_fill < area_end && blk_fill < 128) begin
            kind = $urandom_range(0, sparse ? 39 : 9);
            if (kind == 0) begin
                put_data_block(HDR_CODE_EXT, 5'($urandom_range(1, 7)), EXT_TAG_HDR,
                               8'($urandom & $urandom));
            end else if (kind == 1) begin
                put_data_block(HDR_CODE_EXT, 5'($urandom_range(0, 4)), EXT_TAG_COLOR,
                               8'($urandom & $urandom));
            end else if (kind < 4) begin
                put_data_block(HDR_CODE_EXT, 5'($urandom_range(0, 8)), 8'($urandom),
                               8'($urandom));
            end else begin
                put_data_block(3'($urandom_range(0, 6)),
                               ($urandom_range(0, 4) == 0) ? 5'($urandom)
                                                           : 5'($urandom_range(0, 12)),
                               8'd0, 8'd0);
            end
        end
    endtask

    // Extension block with mostly valid tag and data end
    task automatic add_random_ext_block();
        logic [7:0] tag;
        logic [7:0] ofs;
        int         r;
        tag = ($urandom_range(0, 9) == 0) ? 8'($urandom) : CTA_TAG;
        r   = $urandom_range(0, 9);
        if (r < 7)       ofs = 8'($urandom_range(4, 127));
        else if (r == 7) ofs = 8'd0;
        else if (r == 8) ofs = DATA_END_MAX;
        else             ofs = 8'($urandom);
        start_ext_block(tag, ofs);
        fill_random_blocks((ofs == 8'd0) ? int'(DATA_END_DFLT) : int'(ofs),
                           bit'($urandom_range(0, 1)));
        push_ext_block();
    endtask

    // Move the blob into the send queue, cut to keep bytes if keep is set
    task automatic queue_blob(input int keep, input bit drain_first);
        edid_word_t w;
        int         n;
        n = (keep > 0 && keep < blob_q.size()) ? keep : blob_q.size();
        for (int i = 0; i < n; i++) begin
            w.data       = blob_q[i];
            w.is_last    = (i == n - 1);
            w.wait_drain = drain_first && (i == 0);
            case (gap_style)
                GAP_NONE: w.gap = 0;
                GAP_FULL: w.gap = $urandom_range(0, 15);
                default:  w.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
            endcase
            edid_word_q = {edid_word_q, w};
        end
        bytes_queued += n;
        blobs_queued++;
        blob_q.delete();
    endtask

    // Sender: offer queued words, hold each until accepted, then idle its gap
    always @(posedge aclk) begin : sender
        logic       offer;
        edid_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                track_edid_byte(s_tdata, s_tlast);
                bytes_sent++;
                offer    = 1'b0;
                gap_left = (edid_word_q.size() > 0) ? edid_word_q[0].gap : 0;
            end
            if (!offer && edid_word_q.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(edid_word_q[0].wait_drain && hdr_flags_due_q.size() > 0)) begin
                    w = edid_word_q.pop_front();
                    s_tdata <= w.data;
                    s_tlast <= w.is_last;
                    offer   = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Receiver: random wait before each result, calm stretches, long hold
    always @(posedge aclk) begin : receiver
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = $urandom_range(0, 15);
        end else begin
            if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 11) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
            end
            if (long_hold) begin
                rdy = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // Long stall: starts once the single-byte burst begins, so the block fills
    initial begin : long_stall
        do @(posedge aclk); while (!(aresetn && bytes_sent >= hold_at));
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // Monitor: compare each result word with the oldest expected flags
    always @(posedge aclk) begin : result_check
        hdr_flags_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (hdr_flags_due_q.size() == 0) begin
                report_mismatch($sformatf("result word 0x%02h with no blob pending", m_tdata));
            end else begin
                want = hdr_flags_due_q.pop_front();
                if (m_tdata[0] !== want.pq)
                    report_mismatch($sformatf("result %0d: sink_pq %b, want %b",
                                              results_seen, m_tdata[0], want.pq));
                if (m_tdata[1] !== want.hlg)
                    report_mismatch($sformatf("result %0d: sink_hlg %b, want %b",
                                              results_seen, m_tdata[1], want.hlg));
                if (m_tdata[2] !== want.ycc)
                    report_mismatch($sformatf("result %0d: sink_bt2020_ycc %b, want %b",
                                              results_seen, m_tdata[2], want.ycc));
                if (m_tdata[7:3] !== 5'd0)
                    report_mismatch($sformatf("result %0d: padding bits 0x%02h",
                                              results_seen, m_tdata[7:3]));
                if (want.pq)  pq_seen++;
                if (want.hlg) hlg_seen++;
                if (want.ycc) ycc_seen++;
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int rand_blobs;
        int r;
        int n;
        bit drain_first;

        clear_blob();

        // Single byte and just-short blobs
        blob_q = {blob_q, 8'h00};
        queue_blob(0, 1'b0);
        repeat (127) blob_q = {blob_q, 8'hFF};
        queue_blob(0, 1'b0);

        // All three flags from two extensions at the upper and default data end,
        // every colorimetry block and the first HDR block at its minimum length
        add_base_block(8'd2);
        start_ext_block(CTA_TAG, DATA_END_MAX);
        put_data_block(HDR_CODE_EXT, 5'd3, EXT_TAG_HDR, 8'h04);
        put_data_block(HDR_CODE_EXT, 5'd2, EXT_TAG_COLOR, 8'hBF);
        push_ext_block();
        start_ext_block(CTA_TAG, 8'd0);
        put_data_block(HDR_CODE_EXT, 5'd4, EXT_TAG_HDR, 8'h08);
        put_data_block(HDR_CODE_EXT, 5'd2, EXT_TAG_COLOR, 8'h40);
        push_ext_block();
        queue_blob(0, 1'b0);

        // Wrong tag, data end just below and just above the limits, extended
        // blocks one byte too short followed by a header running past the data
        // end, and a full-flag block beyond the announced count
        add_base_block(8'd4);
        start_ext_block(8'h03, 8'd0);
        put_data_block(HDR_CODE_EXT, 5'd3, EXT_TAG_HDR, 8'hFF);
        push_ext_block();
        start_ext_block(CTA_TAG, 8'd3);
        put_data_block(HDR_CODE_EXT, 5'd3, EXT_TAG_HDR, 8'hFF);
        push_ext_block();
        start_ext_block(CTA_TAG, 8'd129);
        put_data_block(HDR_CODE_EXT, 5'd2, EXT_TAG_COLOR, 8'hFF);
        push_ext_block();
        start_ext_block(CTA_TAG, 8'd12);
        put_data_block(HDR_CODE_EXT, 5'd2, EXT_TAG_HDR, 8'hFF);
        put_data_block(HDR_CODE_EXT, 5'd1, EXT_TAG_COLOR, 8'hFF);
        put_data_block(HDR_CODE_EXT, 5'd5, EXT_TAG_HDR, 8'hFF);
        push_ext_block();
        start_ext_block(CTA_TAG, 8'd0);
        put_data_block(HDR_CODE_EXT, 5'd3, EXT_TAG_HDR, 8'hFF);
        put_data_block(HDR_CODE_EXT, 5'd2, EXT_TAG_COLOR, 8'hFF);
        push_ext_block();
        queue_blob(0, 1'b0);

        // Final block cut before its byte 127
        add_base_block(8'd1);
        start_ext_block(CTA_TAG, 8'd0);
        put_data_block(HDR_CODE_EXT, 5'd3, EXT_TAG_HDR, 8'hFF);
        put_data_block(HDR_CODE_EXT, 5'd2, EXT_TAG_COLOR, 8'hFF);
        push_ext_block();
        queue_blob(255, 1'b0);

        // Burst of one-byte blobs while the receiver holds off
        gap_style = GAP_NONE;
        hold_at   = bytes_queued;
        repeat (BURST_BLOBS) begin
            blob_q = {blob_q, 8'($urandom)};
            queue_blob(0, 1'b0);
        end

        // Random blobs, mostly well formed; the first waits for all results
        rand_blobs = 0;
        while (bytes_queued < ITEM_TARGET || rand_blobs == 0) begin
            gap_style   = gap_style_t'($urandom_range(0, 2));
            drain_first = (rand_blobs == 0) || ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = $urandom_range(1, 3);
                add_base_block(8'(n));
                repeat (n) add_random_ext_block();
                queue_blob((r < 60) ? 0 : $urandom_range(1, blob_q.size() - 1), drain_first);
            end else if (r < 78) begin
                n = $urandom_range(0, 2);
                add_base_block(8'(n));
                repeat (n + $urandom_range(1, 2)) add_random_ext_block();
                queue_blob(0, drain_first);
            end else if (r < 86) begin
                repeat ($urandom_range(1, 127)) blob_q = {blob_q, 8'($urandom)};
                queue_blob(0, drain_first);
            end else if (r < 93) begin
                add_base_block(8'($urandom_range(4, 255)));
                repeat ($urandom_range(1, 2)) add_random_ext_block();
                queue_blob(0, drain_first);
            end else begin
                repeat (128 * $urandom_range(2, 3)) blob_q = {blob_q, 8'($urandom)};
                queue_blob(0, drain_first);
            end
            rand_blobs++;
        end

        // Reset, then let the sender run
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (edid_word_q.size() != 0 || s_tvalid) @(posedge aclk);
        for (int i = 0; i < 5000 && hdr_flags_due_q.size() != 0; i++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (hdr_flags_due_q.size() != 0) begin
            report_mismatch($sformatf("%0d blob results never arrived",
                                      hdr_flags_due_q.size()));
        end

        $display("Sent %0d bytes in %0d blobs, checked %0d result words, %0d mismatches",
                 bytes_sent, blobs_queued, results_seen, mismatch_cnt);
        $display("Flags expected set: PQ %0d, HLG %0d, BT.2020 YCC %0d",
                 pq_seen, hlg_seen, ycc_seen);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #100_000_000;
        $display("Timeout: %0d of %0d bytes sent, %0d results pending",
                 bytes_sent, bytes_queued, hdr_flags_due_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
